// ===== rtl/core/gra_pkg.sv =====
// ----------------------------------------------------------------------------
// gra_pkg
// Types and constants shared by the grid rectangle allocator.
// ----------------------------------------------------------------------------
package gra_pkg;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 7;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 1'b1;

    localparam logic [CFG_DATA_W-1:0] GRID_DIM_RESET = 7'd64;

    // operation codes
    localparam logic [1:0] OP_PLACE = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OUTSIDE = 2'd1;
    localparam logic [1:0] ST_OVERLAP = 2'd2;
    localparam logic [1:0] ST_BADKIND = 2'd3;

    localparam logic [1:0] KIND_EMPTY = 2'd0;

    typedef struct packed {
        logic [1:0] opcode;
        logic [5:0] pos_x;
        logic [5:0] pos_y;
        logic [6:0] rect_width;
        logic [6:0] rect_height;
        logic [1:0] kind;
    } t_cmd;

    typedef struct packed {
        logic [1:0] status;
        logic [1:0] cell_kind;
    } t_res;

endpackage

// ===== rtl/core/grid_rectangle_allocator_core.sv =====
// ----------------------------------------------------------------------------
// grid_rectangle_allocator_core
// Occupancy grid with place, clear and read-cell operations on rectangles.
// ----------------------------------------------------------------------------
// The grid is held one row per memory word, and a single row pipeline reads,
// tests and rewrites rows one per cycle. A place of height h scans its rows
// for occupied cells and then rewrites them; a clear rewrites its rows with no
// scan, a read fetches a single row, and a rejected command or the unused
// opcode ends without touching the grid. busy stays high until the
// last row is written; the result shows for one cycle with o_done and cannot
// be held off, and the next start may come in that same cycle. Rows carry a
// valid bit cleared by reset, so no clearing pass is needed after reset.
// Configuration writes are always taken (o_cfg_ready is tied high).
module grid_rectangle_allocator_core #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  gra_pkg::t_cmd                 i_cmd,
    output logic                          o_done,
    output gra_pkg::t_res                 o_res,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [gra_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gra_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int RowAw  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int RowW   = 2 * MAX_COLS;
    localparam int RowCap = (MAX_ROWS > 127) ? 127 : MAX_ROWS;
    localparam int ColCap = (MAX_COLS > 127) ? 127 : MAX_COLS;

    typedef logic [MAX_COLS-1:0][1:0] t_row;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_FILL = 4'b0100,
        S_READ = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [6:0]          r_rows, r_cols;
    logic [1:0]          r_op, n_op;
    logic [5:0]          r_x, n_x;
    logic [5:0]          r_y, n_y;
    logic [6:0]          r_h, n_h;
    logic [1:0]          r_tag, n_tag;
    logic [MAX_COLS-1:0] r_mask, n_mask;
    logic [6:0]          r_cnt, n_cnt;
    logic                r_pend, n_pend;
    logic [RowAw-1:0]    r_prow, n_prow;
    logic [MAX_ROWS-1:0] r_vld, n_vld;
    logic                r_done, n_done;
    gra_pkg::t_res       r_res, n_res;

    logic [6:0]       w_rows_used, w_cols_used;
    logic [7:0]       w_sum_x, w_sum_y, w_cmd_row8, w_issue_row8;
    logic             w_inside, w_rd_inside, w_issue, w_hit, w_we;
    logic [RowW-1:0]  w_rdata;
    logic [RowAw-1:0] w_raddr;
    t_row             w_cells, w_merged;
    logic [1:0]       w_sel;

    assign w_rows_used = (r_rows > 7'(RowCap)) ? 7'(RowCap) : r_rows;
    assign w_cols_used = (r_cols > 7'(ColCap)) ? 7'(ColCap) : r_cols;

    assign w_sum_x = {2'b0, i_cmd.pos_x} + {1'b0, i_cmd.rect_width};
    assign w_sum_y = {2'b0, i_cmd.pos_y} + {1'b0, i_cmd.rect_height};
    assign w_inside = (w_sum_x <= {1'b0, w_cols_used}) && (w_sum_y <= {1'b0, w_rows_used});
    assign w_rd_inside = ({1'b0, i_cmd.pos_x} < w_cols_used)
                      && ({1'b0, i_cmd.pos_y} < w_rows_used);

    assign w_cmd_row8   = {2'b0, i_cmd.pos_y};
    assign w_issue_row8 = {2'b0, r_y} + {1'b0, r_cnt};
    assign w_issue      = (r_cnt < r_h);
    assign w_raddr      = (r_state == S_IDLE) ? w_cmd_row8[RowAw-1:0]
                                              : w_issue_row8[RowAw-1:0];

    // a row never written reads as empty
    assign w_cells = r_vld[r_prow] ? t_row'(w_rdata) : '0;

    always_comb begin
        w_hit = 1'b0;
        w_sel = gra_pkg::KIND_EMPTY;
        for (int c = 0; c < MAX_COLS; c++) begin
            w_merged[c] = r_mask[c] ? r_tag : w_cells[c];
            if (r_mask[c] && (w_cells[c] != gra_pkg::KIND_EMPTY)) begin
                w_hit = 1'b1;
            end
            if (8'(c) == {2'b0, r_x}) begin
                w_sel = w_cells[c];
            end
        end
    end

    assign w_we = (r_state == S_FILL) && r_pend;

    gra_ram #(
        .WIDTH (RowW),
        .DEPTH (MAX_ROWS)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_prow),
        .i_wdata (RowW'(w_merged)),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_x     = r_x;
        n_y     = r_y;
        n_h     = r_h;
        n_tag   = r_tag;
        n_mask  = r_mask;
        n_cnt   = r_cnt;
        n_pend  = 1'b0;
        n_prow  = r_prow;
        n_vld   = r_vld;
        n_done  = 1'b0;
        n_res   = r_res;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op   = i_cmd.opcode;
                    n_x    = i_cmd.pos_x;
                    n_y    = i_cmd.pos_y;
                    n_h    = i_cmd.rect_height;
                    n_tag  = i_cmd.kind;
                    n_cnt  = '0;
                    n_prow = w_cmd_row8[RowAw-1:0];
                    for (int c = 0; c < MAX_COLS; c++) begin
                        n_mask[c] = (9'(c) >= {3'b0, i_cmd.pos_x})
                                 && (9'(c) < {1'b0, w_sum_x});
                    end
                    n_res.cell_kind = gra_pkg::KIND_EMPTY;
                    n_res.status    = gra_pkg::ST_OK;
                    case (i_cmd.opcode)
                        gra_pkg::OP_PLACE: begin
                            if (i_cmd.kind == gra_pkg::KIND_EMPTY) begin
                                n_res.status = gra_pkg::ST_BADKIND;
                                n_done       = 1'b1;
                            end else if (!w_inside) begin
                                n_res.status = gra_pkg::ST_OUTSIDE;
                                n_done       = 1'b1;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        gra_pkg::OP_CLEAR: begin
                            n_tag = gra_pkg::KIND_EMPTY;
                            if (!w_inside) begin
                                n_res.status = gra_pkg::ST_OUTSIDE;
                                n_done       = 1'b1;
                            end else begin
                                n_state = S_FILL;
                            end
                        end
                        gra_pkg::OP_READ: begin
                            if (!w_rd_inside) begin
                                n_res.status = gra_pkg::ST_OUTSIDE;
                                n_done       = 1'b1;
                            end else begin
                                // row read already issued this cycle
                                n_pend  = 1'b1;
                                n_state = S_READ;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN, S_FILL: begin
                if (w_issue) begin
                    n_cnt  = r_cnt + 7'd1;
                    n_pend = 1'b1;
                    n_prow = w_issue_row8[RowAw-1:0];
                end
                if (r_pend && (r_state == S_FILL)) begin
                    n_vld[r_prow] = 1'b1;
                end
                if (r_pend && (r_state == S_SCAN) && w_hit) begin
                    n_res.status = gra_pkg::ST_OVERLAP;
                    n_done       = 1'b1;
                    n_pend       = 1'b0;
                    n_state      = S_IDLE;
                end else if (!w_issue && !r_pend) begin
                    n_cnt = '0;
                    if (r_state == S_SCAN) begin
                        n_state = S_FILL;
                    end else begin
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            S_READ: begin
                n_res.cell_kind = w_sel;
                n_done          = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rows  <= gra_pkg::GRID_DIM_RESET;
            r_cols  <= gra_pkg::GRID_DIM_RESET;
            r_cnt   <= '0;
            r_pend  <= 1'b0;
            r_vld   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pend  <= n_pend;
            r_vld   <= n_vld;
            r_done  <= n_done;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == gra_pkg::CFG_GRID_ROWS) begin
                    r_rows <= i_cfg_data;
                end
                if (i_cfg_index == gra_pkg::CFG_GRID_COLS) begin
                    r_cols <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_x    <= n_x;
        r_y    <= n_y;
        r_h    <= n_h;
        r_tag  <= n_tag;
        r_mask <= n_mask;
        r_prow <= n_prow;
        r_res  <= n_res;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_done      = r_done;
    assign o_res       = r_res;
    assign o_cfg_ready = 1'b1;

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state register not one-hot");

    a_write_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_FILL))
        else $error("grid written outside the fill pass");

    a_done_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(busy) || $past(start)))
        else $error("result without a transaction in flight");

    a_overlap_only_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_res.status == gra_pkg::ST_OVERLAP)) |-> (r_op == gra_pkg::OP_PLACE))
        else $error("overlap status for an operation other than place");

endmodule

// ===== rtl/core/gra_ram.sv =====
// ----------------------------------------------------------------------------
// gra_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module gra_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 64
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
